[rtl/rie_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rie_pkg;

    localparam int unsigned MAX_INSTRUCTIONS = 4096;
    localparam int unsigned MEMORY_BYTES     = 65536;
    localparam int unsigned REG_COUNT        = 32;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENTRY_PC    = 2'd0,
        CFG_INSTR_COUNT = 2'd1,
        CFG_MEMORY_BASE = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NOP   = 5'd0,  OP_LI    = 5'd1,  OP_MOVE  = 5'd2,  OP_MFHI  = 5'd3,
        OP_MFLO  = 5'd4,  OP_LW    = 5'd5,  OP_SW    = 5'd6,  OP_LA    = 5'd7,
        OP_ADD   = 5'd8,  OP_SUB   = 5'd9,  OP_ADDU  = 5'd10, OP_SUBU  = 5'd11,
        OP_AND   = 5'd12, OP_OR    = 5'd13, OP_XOR   = 5'd14, OP_NOR   = 5'd15,
        OP_NOT   = 5'd16, OP_MULT  = 5'd17, OP_MULTU = 5'd18, OP_DIV   = 5'd19,
        OP_DIVU  = 5'd20, OP_J     = 5'd21, OP_BEQ   = 5'd22, OP_BNE   = 5'd23,
        OP_BLT   = 5'd24, OP_BLE   = 5'd25, OP_BGT   = 5'd26, OP_BGE   = 5'd27
    } t_op;

    typedef enum logic [2:0] {
        F_NONE  = 3'd0,
        F_ENTRY = 3'd1,
        F_PC    = 3'd2,
        F_UNSUP = 3'd3,
        F_OVF   = 3'd4,
        F_MEM   = 3'd5,
        F_ADDR  = 3'd6,
        F_OPND  = 3'd7
    } t_fault;

    // how an instruction finishes after the execute cycle
    typedef enum logic [1:0] {
        K_DONE = 2'd0,
        K_LOAD = 2'd1,
        K_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [4:0]         operation;
        logic [4:0]         dest_reg;
        logic [4:0]         first_reg;
        logic               source_is_immediate;
        logic [31:0]        source_value;
        logic signed [31:0] address_offset;
        logic [11:0]        branch_target;
        logic               three_operand;
        logic [15:0]        source_line;
    } t_in_word;

    typedef struct packed {
        logic        executed_ok;
        logic [2:0]  fault_code;
        logic [12:0] program_counter;
        logic [15:0] fault_line;
        logic [31:0] fault_address;
        logic [31:0] executed_count;
    } t_out_word;

    typedef struct packed {
        logic take;
        logic rd1;
        logic rd2;
        logic addr;
        logic exec;
        logic fin_load;
        logic div_step;
        logic fin_div;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic  out_free;
        t_kind kind;
        logic  div_last;
        logic  clr_last;
    } t_stat;

endpackage

`default_nettype wire

[rtl/rie_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rie_pkg::t_stat i_stat,
    output rie_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_ADDR, S_EXEC, S_LOAD, S_DIV, S_DIVF
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_RD1;
                end
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    unique case (i_stat.kind)
                        rie_pkg::K_LOAD: n_state = S_LOAD;
                        rie_pkg::K_DIV:  n_state = S_DIV;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_DIVF;
            end
            S_DIVF: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_div = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("memory clear pass entered again");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.fin_load || o_cmd.fin_div) |-> i_stat.out_free)
        else $error("commit while output register busy");

endmodule

`default_nettype wire

[rtl/rie_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rie_dpath #(
    parameter int unsigned MEMORY_BYTES = rie_pkg::MEMORY_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rie_pkg::t_cmd     i_cmd,
    output rie_pkg::t_stat         o_stat,
    input  wire rie_pkg::t_in_word i_in_word,
    input  wire logic [11:0]       i_entry_pc,
    input  wire logic [12:0]       i_instr_count,
    input  wire logic [31:0]       i_memory_base,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output rie_pkg::t_out_word     o_out_word
);

    localparam int unsigned ROWS  = (MEMORY_BYTES + 3) / 4;
    localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned OFF_W = $clog2(MEMORY_BYTES);

    // captured instruction and operands
    rie_pkg::t_in_word r_in;
    logic [31:0]       r_a, r_b, r_x;
    logic [31:0]       r_ea;
    rie_pkg::t_fault   r_ea_flt;
    logic [OFF_W-1:0]  r_off;
    logic              r_in1, r_in4;

    // architectural state
    logic [31:0]       rf [rie_pkg::REG_COUNT];
    logic [31:0]       r_rf_vld;
    logic [12:0]       r_pc, n_pc;
    logic              r_started, n_started;
    logic              r_err, n_err;
    logic [31:0]       r_cnt, n_cnt;
    rie_pkg::t_fault   r_hcode, n_hcode;
    logic [15:0]       r_hline, n_hline;
    logic [31:0]       r_haddr, n_haddr;
    logic [31:0]       r_hi, n_hi, r_lo, n_lo;

    // byte lanes of data memory
    logic [7:0]        mem_bank [4][ROWS];
    logic [7:0]        r_mq [4];
    logic [RW-1:0]     bank_row [4];
    logic [7:0]        bank_wd [4];
    logic              bank_we [4];
    logic [RW-1:0]     r_clr;

    // divider
    logic [31:0]       r_dq, r_rem, r_dvs;
    logic [4:0]        r_dcnt;
    logic              r_qneg, r_rneg;

    logic              r_ovld;
    rie_pkg::t_out_word r_out;

    // shared wires
    logic [12:0]       len, pc_eff;
    logic              src_bad, tgt_bad, unsup;
    logic [31:0]       src;
    logic [33:0]       ea_sum;
    logic [31:0]       mdist;
    logic              mge;

    assign len = (32'(i_instr_count) > 32'(rie_pkg::MAX_INSTRUCTIONS))
               ? 13'(rie_pkg::MAX_INSTRUCTIONS) : i_instr_count;
    assign pc_eff  = r_started ? r_pc : {1'b0, i_entry_pc};
    assign src_bad = !r_in.source_is_immediate && (r_in.source_value[31:5] != 27'd0);
    assign src     = r_in.source_is_immediate ? r_in.source_value : r_b;
    assign tgt_bad = ({1'b0, r_in.branch_target} >= len);
    assign unsup   = (r_in.operation > rie_pkg::OP_BGE)
                   || (((r_in.operation == rie_pkg::OP_DIV)
                       || (r_in.operation == rie_pkg::OP_DIVU)) && r_in.three_operand);
    assign ea_sum  = {2'b00, src} + {{2{r_in.address_offset[31]}}, r_in.address_offset};
    assign mge     = (r_ea >= i_memory_base);
    assign mdist   = r_ea - i_memory_base;

    // multiplier
    logic               mul_s;
    logic signed [32:0] mx, my;
    logic signed [65:0] prod;
    assign mul_s = (r_in.operation == rie_pkg::OP_MULT);
    assign mx    = {mul_s & r_x[31], r_x};
    assign my    = {mul_s & r_a[31], r_a};
    assign prod  = mx * my;

    // add / sub with overflow
    logic [32:0] add33, sub33;
    assign add33 = {r_a[31], r_a} + {src[31], src};
    assign sub33 = {r_a[31], r_a} - {src[31], src};

    logic br_eq, br_lt;
    assign br_eq = (r_a == src);
    assign br_lt = ($signed(r_a) < $signed(src));

    // execute decision
    rie_pkg::t_fault e_fault;
    rie_pkg::t_kind  e_kind;
    logic [15:0]     e_line;
    logic [31:0]     e_addr, e_wdat, e_hi, e_lo;
    logic [12:0]     e_next;
    logic            e_wen, e_hlwen, e_memwr, e_take;

    always_comb begin
        e_fault = rie_pkg::F_NONE;
        e_kind  = rie_pkg::K_DONE;
        e_line  = r_in.source_line;
        e_addr  = '0;
        e_next  = pc_eff + 13'd1;
        e_wen   = 1'b0;
        e_wdat  = src;
        e_hlwen = 1'b0;
        e_hi    = prod[63:32];
        e_lo    = prod[31:0];
        e_memwr = 1'b0;
        e_take  = 1'b0;
        if (!r_started && ({1'b0, i_entry_pc} >= len)) begin
            e_fault = rie_pkg::F_ENTRY;
            e_line  = 16'd1;
        end else if (pc_eff >= len) begin
            e_fault = rie_pkg::F_PC;
            e_line  = '0;
        end else if (unsup) begin
            e_fault = rie_pkg::F_UNSUP;
        end else begin
            unique case (r_in.operation)
                rie_pkg::OP_NOP: ;
                rie_pkg::OP_LI: begin
                    if (src_bad) e_fault = rie_pkg::F_OPND;
                    else e_wen = 1'b1;
                end
                rie_pkg::OP_MOVE: begin
                    e_wen  = 1'b1;
                    e_wdat = r_a;
                end
                rie_pkg::OP_MFHI: begin
                    e_wen  = 1'b1;
                    e_wdat = r_hi;
                end
                rie_pkg::OP_MFLO: begin
                    e_wen  = 1'b1;
                    e_wdat = r_lo;
                end
                rie_pkg::OP_LW, rie_pkg::OP_SW, rie_pkg::OP_LA: begin
                    if (r_ea_flt != rie_pkg::F_NONE) begin
                        e_fault = r_ea_flt;
                    end else if (r_in.operation == rie_pkg::OP_LA) begin
                        if (!r_in1) e_fault = rie_pkg::F_ADDR;
                        else begin
                            e_wen  = 1'b1;
                            e_wdat = r_ea;
                        end
                    end else if (!r_in4) begin
                        e_fault = rie_pkg::F_MEM;
                        e_addr  = r_ea;
                    end else if (r_in.operation == rie_pkg::OP_LW) begin
                        e_kind = rie_pkg::K_LOAD;
                    end else begin
                        e_memwr = 1'b1;
                    end
                end
                rie_pkg::OP_ADD, rie_pkg::OP_SUB, rie_pkg::OP_ADDU, rie_pkg::OP_SUBU,
                rie_pkg::OP_AND, rie_pkg::OP_OR, rie_pkg::OP_XOR, rie_pkg::OP_NOR,
                rie_pkg::OP_NOT: begin
                    if (src_bad) begin
                        e_fault = rie_pkg::F_OPND;
                    end else begin
                        e_wen = 1'b1;
                        unique case (r_in.operation)
                            rie_pkg::OP_ADD: begin
                                e_wdat = add33[31:0];
                                if (add33[32] != add33[31]) e_fault = rie_pkg::F_OVF;
                            end
                            rie_pkg::OP_SUB: begin
                                e_wdat = sub33[31:0];
                                if (sub33[32] != sub33[31]) e_fault = rie_pkg::F_OVF;
                            end
                            rie_pkg::OP_ADDU: e_wdat = add33[31:0];
                            rie_pkg::OP_SUBU: e_wdat = sub33[31:0];
                            rie_pkg::OP_AND:  e_wdat = r_a & src;
                            rie_pkg::OP_OR:   e_wdat = r_a | src;
                            rie_pkg::OP_XOR:  e_wdat = r_a ^ src;
                            rie_pkg::OP_NOR:  e_wdat = ~(r_a | src);
                            default:          e_wdat = ~src;
                        endcase
                    end
                end
                rie_pkg::OP_MULT, rie_pkg::OP_MULTU: e_hlwen = 1'b1;
                rie_pkg::OP_DIV, rie_pkg::OP_DIVU: begin
                    if (r_a != 32'd0) e_kind = rie_pkg::K_DIV;
                end
                rie_pkg::OP_J: begin
                    if (tgt_bad) e_fault = rie_pkg::F_OPND;
                    else e_next = {1'b0, r_in.branch_target};
                end
                rie_pkg::OP_BEQ, rie_pkg::OP_BNE, rie_pkg::OP_BLT, rie_pkg::OP_BLE,
                rie_pkg::OP_BGT, rie_pkg::OP_BGE: begin
                    unique case (r_in.operation)
                        rie_pkg::OP_BEQ: e_take = br_eq;
                        rie_pkg::OP_BNE: e_take = !br_eq;
                        rie_pkg::OP_BLT: e_take = br_lt;
                        rie_pkg::OP_BLE: e_take = br_lt || br_eq;
                        rie_pkg::OP_BGT: e_take = !(br_lt || br_eq);
                        default:         e_take = !br_lt;
                    endcase
                    if (src_bad) e_fault = rie_pkg::F_OPND;
                    else if (e_take) begin
                        if (tgt_bad) e_fault = rie_pkg::F_OPND;
                        else e_next = {1'b0, r_in.branch_target};
                    end
                end
                default: e_fault = rie_pkg::F_UNSUP;
            endcase
        end
    end

    // load word assembly, little-endian over the four lanes
    logic [31:0] ld_word;
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            ld_word[8*j +: 8] = r_mq[2'(r_off[1:0] + 2'(j))];
        end
    end

    // commit
    logic        out_load, out_ok, rf_wen, mem_wr;
    logic [31:0] rf_wdat;

    always_comb begin
        n_pc      = r_pc;
        n_started = r_started;
        n_err     = r_err;
        n_cnt     = r_cnt;
        n_hcode   = r_hcode;
        n_hline   = r_hline;
        n_haddr   = r_haddr;
        n_hi      = r_hi;
        n_lo      = r_lo;
        out_load  = 1'b0;
        out_ok    = 1'b0;
        rf_wen    = 1'b0;
        rf_wdat   = e_wdat;
        mem_wr    = 1'b0;
        if (i_cmd.exec) begin
            out_load = r_err || (e_kind == rie_pkg::K_DONE);
            if (!r_err) begin
                n_started = 1'b1;
                n_pc      = pc_eff;
                if (e_fault != rie_pkg::F_NONE) begin
                    n_err   = 1'b1;
                    n_hcode = e_fault;
                    n_hline = e_line;
                    n_haddr = e_addr;
                end else if (e_kind == rie_pkg::K_DONE) begin
                    n_pc   = e_next;
                    n_cnt  = r_cnt + 32'd1;
                    out_ok = 1'b1;
                    rf_wen = e_wen;
                    mem_wr = e_memwr;
                    if (e_hlwen) begin
                        n_hi = e_hi;
                        n_lo = e_lo;
                    end
                end
            end
        end
        if (i_cmd.fin_load) begin
            n_pc     = r_pc + 13'd1;
            n_cnt    = r_cnt + 32'd1;
            out_ok   = 1'b1;
            out_load = 1'b1;
            rf_wen   = 1'b1;
            rf_wdat  = ld_word;
        end
        if (i_cmd.fin_div) begin
            n_pc     = r_pc + 13'd1;
            n_cnt    = r_cnt + 32'd1;
            out_ok   = 1'b1;
            out_load = 1'b1;
            n_lo     = r_qneg ? (32'd0 - r_dq) : r_dq;
            n_hi     = r_rneg ? (32'd0 - r_rem) : r_rem;
        end
    end

    // memory lane addressing: clear sweep or the load or store word
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_cmd.clr) begin
                bank_row[k] = r_clr;
                bank_wd[k]  = 8'd0;
                bank_we[k]  = 1'b1;
            end else begin
                bank_row[k] = RW'((32'(r_off) >> 2)
                            + ((2'(k) < r_off[1:0]) ? 32'd1 : 32'd0));
                bank_wd[k]  = r_x[{2'(2'(k) - r_off[1:0]), 3'b000} +: 8];
                bank_we[k]  = mem_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (bank_we[k]) mem_bank[k][bank_row[k]] <= bank_wd[k];
            if (i_cmd.exec) r_mq[k] <= mem_bank[k][bank_row[k]];
        end
    end

    // register file, read ports registered
    always_ff @(posedge i_clk) begin
        if (rf_wen && (r_in.dest_reg != 5'd0)) rf[r_in.dest_reg] <= rf_wdat;
        if (i_cmd.rd1) begin
            r_a <= r_rf_vld[r_in.first_reg] ? rf[r_in.first_reg] : 32'd0;
            r_b <= r_rf_vld[r_in.source_value[4:0]] ? rf[r_in.source_value[4:0]] : 32'd0;
        end
        if (i_cmd.rd2) begin
            r_x <= r_rf_vld[r_in.dest_reg] ? rf[r_in.dest_reg] : 32'd0;
        end
    end

    // payload and divider registers
    logic [32:0] dv_t, dv_d;
    logic        dv_ge, dx_neg, dy_neg;
    assign dv_t   = {r_rem, r_dq[31]};
    assign dv_d   = dv_t - {1'b0, r_dvs};
    assign dv_ge  = (dv_t >= {1'b0, r_dvs});
    assign dx_neg = (r_in.operation == rie_pkg::OP_DIV) && r_x[31];
    assign dy_neg = (r_in.operation == rie_pkg::OP_DIV) && r_a[31];

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_in <= i_in_word;
        if (i_cmd.rd2) begin
            r_ea     <= ea_sum[31:0];
            r_ea_flt <= src_bad ? rie_pkg::F_OPND
                      : ((ea_sum[33:32] != 2'b00) ? rie_pkg::F_ADDR : rie_pkg::F_NONE);
        end
        if (i_cmd.addr) begin
            r_off <= OFF_W'(mdist);
            r_in1 <= mge && (mdist <= 32'(MEMORY_BYTES - 1));
            r_in4 <= mge && (mdist <= 32'(MEMORY_BYTES - 4));
        end
        if (i_cmd.exec) begin
            r_dq   <= dx_neg ? (32'd0 - r_x) : r_x;
            r_dvs  <= dy_neg ? (32'd0 - r_a) : r_a;
            r_rem  <= 32'd0;
            r_dcnt <= 5'd0;
            r_qneg <= dx_neg ^ dy_neg;
            r_rneg <= dx_neg;
        end
        if (i_cmd.div_step) begin
            r_rem  <= dv_ge ? dv_d[31:0] : dv_t[31:0];
            r_dq   <= {r_dq[30:0], dv_ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (out_load) begin
            r_out.executed_ok     <= out_ok;
            r_out.fault_code      <= n_hcode;
            r_out.program_counter <= n_pc;
            r_out.fault_line      <= n_hline;
            r_out.fault_address   <= n_haddr;
            r_out.executed_count  <= n_cnt;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_started <= 1'b0;
            r_err     <= 1'b0;
            r_cnt     <= '0;
            r_hcode   <= rie_pkg::F_NONE;
            r_hline   <= '0;
            r_haddr   <= '0;
            r_hi      <= '0;
            r_lo      <= '0;
            r_rf_vld  <= '0;
            r_clr     <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_started <= n_started;
            r_err     <= n_err;
            r_cnt     <= n_cnt;
            r_hcode   <= n_hcode;
            r_hline   <= n_hline;
            r_haddr   <= n_haddr;
            r_hi      <= n_hi;
            r_lo      <= n_lo;
            if (rf_wen && (r_in.dest_reg != 5'd0)) r_rf_vld[r_in.dest_reg] <= 1'b1;
            if (i_cmd.clr) r_clr <= r_clr + RW'(1);
            if (out_load) r_ovld <= 1'b1;
            else if (i_out_ready) r_ovld <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_ovld || i_out_ready;
    assign o_stat.kind     = r_err ? rie_pkg::K_DONE : e_kind;
    assign o_stat.div_last = (r_dcnt == 5'd31);
    assign o_stat.clr_last = (r_clr == RW'(ROWS - 1));
    assign o_out_valid     = r_ovld;
    assign o_out_word      = r_out;

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> (r_err && $stable(r_pc) && $stable(r_cnt)))
        else $error("state changed while halted");

    a_ok_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_out.executed_ok) |-> (r_out.fault_code == rie_pkg::F_NONE))
        else $error("completed word carries a fault code");

    a_cnt_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> $past(out_load && out_ok))
        else $error("count moved without a completed word");

endmodule

`default_nettype wire

[rtl/risc_instruction_execute_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// executes one decoded instruction per input word against 32 registers, hi/lo, the pc
// and a byte-addressed little-endian data memory, and returns one status word per input
// word; after reset the data memory is swept to zero one 4-byte row a cycle, and no word
// is accepted until the sweep finishes; an accepted word passes through the sequencer's
// operand reads, address step and execute step, a load then through a load finish step,
// and a divide with a nonzero divisor through the 32-step shift-subtract divider and a
// divide finish step; the result word is registered in the output register as ready
// returns; a stalled output holds the sequencer in its commit step; words are taken one
// at a time, a new word may be accepted while the previous result word still waits in
// the output register
module risc_instruction_execute_step #(
    parameter int unsigned MEMORY_BYTES = rie_pkg::MEMORY_BYTES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input words
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rie_pkg::t_in_word  i_in_word,
    // result words
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rie_pkg::t_out_word      o_out_word,
    // configuration writes
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    // configuration registers
    logic [11:0] r_entry_pc;
    logic [12:0] r_instr_count;
    logic [31:0] r_mem_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_pc    <= '0;
            r_instr_count <= '0;
            r_mem_base    <= '0;
        end else if (i_cfg_we) begin
            // an index past the list is ignored
            unique case (i_cfg_index)
                rie_pkg::CFG_ENTRY_PC:    r_entry_pc    <= i_cfg_data[11:0];
                rie_pkg::CFG_INSTR_COUNT: r_instr_count <= i_cfg_data[12:0];
                rie_pkg::CFG_MEMORY_BASE: r_mem_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer to datapath commands and status
    rie_pkg::t_cmd  cmd;
    rie_pkg::t_stat stat;

    rie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // registers, memory lanes, multiplier, divider and output register
    rie_dpath #(
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_word     (i_in_word),
        .i_entry_pc    (r_entry_pc),
        .i_instr_count (r_instr_count),
        .i_memory_base (r_mem_base),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word)
    );

endmodule

`default_nettype wire
